// File: src/knn_pkg.sv
// Shared types and constants for the nearest-neighbor vote filter.
package knn_pkg;

  localparam int COUNT_BITS = 5;
  localparam int CFG_BITS   = 5;

  localparam logic [CFG_BITS-1:0] DEFAULT_NEIGHBORS = 5'd10;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_CAND  = 1'b1;

  // Qualified strobes from the pipeline into the kept-list unit.
  typedef struct packed {
    logic start;
    logic cand;
  } knn_ctl_t;

  // Vote over the kept list after the current candidate.
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  keep;
  } knn_vote_t;

endpackage

// File: src/knn_ifs.sv
// Valid/ready channel interfaces for pixel beats in and vote beats out.
interface knn_in_if #(
  parameter int CHAN_W  = 16,
  parameter int LABEL_W = 4
) ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;
  logic [LABEL_W-1:0] label;
  logic               last;

  modport source (output valid, cmd, red, green, blue, label, last, input ready);
  modport sink   (input valid, cmd, red, green, blue, label, last, output ready);
endinterface

interface knn_out_if ();
  import knn_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] same_label_count;
  logic                  keep;

  modport source (output valid, same_label_count, keep, input ready);
  modport sink   (input valid, same_label_count, keep, output ready);
endinterface

// File: src/knn_majority_vote_filter.sv
// Top level of the k-nearest-neighbor majority vote filter.
//
// A start beat (cmd = 0) loads the query color and query label and empties
// the kept list; each candidate beat (cmd = 1) has its squared RGB distance
// to the query taken and is kept among the K nearest, K being the
// neighbor_count register clamped to 1..MAX_NEIGHBORS. While fewer than K are
// kept the candidate is added; otherwise it evicts the farthest kept entry
// (lowest slot on a distance tie) only when strictly nearer. A candidate with
// last = 1 yields one vote beat: how many kept entries carry the query label,
// and keep = count >= K/2. Start beats and candidates without last give no
// beat. Throughput is one beat per clock while no voting beat is held by the
// output; a beat passes from the input register to the distance register and
// then to the vote register. The per-cycle limit is the kept-list update:
// all entries compare against the new distance in parallel and the whole
// list shifts at once. Non-voting beats keep flowing while a vote beat
// waits on the output. Write neighbor_count only while the block is idle.
module knn_majority_vote_filter #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int LABEL_BITS    = 4,
  parameter int CHANNEL_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [knn_pkg::CFG_BITS-1:0]  cfg_wdata,
  knn_in_if.sink                        pixel,
  knn_out_if.source                     vote
);
  import knn_pkg::*;

  localparam int DIST_W = 2 * CHANNEL_BITS + 2;

  logic [CFG_BITS-1:0] neighbor_count;

  // stage 1: accepted beat
  logic                    s1_valid;
  logic                    s1_cmd;
  logic [CHANNEL_BITS-1:0] s1_red, s1_green, s1_blue;
  logic [LABEL_BITS-1:0]   s1_label;
  logic                    s1_last;

  // query color, updated as a start beat leaves stage 1
  logic [CHANNEL_BITS-1:0] q_red, q_green, q_blue;

  // stage 2: distance
  logic                    s2_valid;
  logic                    s2_cmd;
  logic [DIST_W-1:0]       s2_dist;
  logic [LABEL_BITS-1:0]   s2_label;
  logic                    s2_last;

  // vote register
  logic                    res_valid;
  knn_vote_t               res;

  logic [DIST_W-1:0]       s1_dist;
  logic                    s2_votes, res_free, s2_go, s2_open, s1_go;
  knn_ctl_t                ctl;
  knn_vote_t               vote_now;

  // Handshake chain: a stage moves when the one after it has room.
  // Only voting beats wait on the vote register.
  always_comb begin
    s2_votes    = (s2_cmd == CMD_CAND) && s2_last;
    res_free    = !res_valid || vote.ready;
    s2_go       = s2_valid && (!s2_votes || res_free);
    s2_open     = !s2_valid || s2_go;
    s1_go       = s1_valid && s2_open;
    pixel.ready = !s1_valid || s2_open;
    ctl.start   = s2_go && (s2_cmd == CMD_START);
    ctl.cand    = s2_go && (s2_cmd == CMD_CAND);
  end

  knn_dist #(
    .CHAN_W (CHANNEL_BITS)
  ) u_dist (
    .red     (s1_red),
    .green   (s1_green),
    .blue    (s1_blue),
    .q_red   (q_red),
    .q_green (q_green),
    .q_blue  (q_blue),
    .dist_sq (s1_dist)
  );

  knn_list #(
    .N       (MAX_NEIGHBORS),
    .LABEL_W (LABEL_BITS),
    .DIST_W  (DIST_W)
  ) u_list (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .dist_sq        (s2_dist),
    .label          (s2_label),
    .neighbor_count (neighbor_count),
    .vote           (vote_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count <= DEFAULT_NEIGHBORS;
    end else if (cfg_we) begin
      neighbor_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.ready) begin
      s1_cmd   <= pixel.cmd;
      s1_red   <= pixel.red;
      s1_green <= pixel.green;
      s1_blue  <= pixel.blue;
      s1_label <= pixel.label;
      s1_last  <= pixel.last;
    end
  end

  // A candidate entering stage 1 on the same edge sees the new query.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_red   <= '0;
      q_green <= '0;
      q_blue  <= '0;
    end else if (s1_go && (s1_cmd == CMD_START)) begin
      q_red   <= s1_red;
      q_green <= s1_green;
      q_blue  <= s1_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_open) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_open) begin
      s2_cmd   <= s1_cmd;
      s2_dist  <= s1_dist;
      s2_label <= s1_label;
      s2_last  <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_go && s2_votes) begin
      res_valid <= 1'b1;
    end else if (vote.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_votes) begin
      res <= vote_now;
    end
  end

  assign vote.valid            = res_valid;
  assign vote.same_label_count = res.count;
  assign vote.keep             = res.keep;

  a_vote_room: assert property (@(posedge clk) disable iff (rst)
    (s2_go && s2_votes) |-> res_free)
    else $error("vote beat overwritten");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_go) |=> s2_valid && $stable(s2_dist))
    else $error("stalled distance stage lost its beat");

  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> !$rose(res_valid))
    else $error("start beat produced a vote");

endmodule

// File: src/knn_dist.sv
// Squared RGB distance between a candidate color and the query color.
module knn_dist #(
  parameter int CHAN_W = 16
) (
  input  logic [CHAN_W-1:0]   red,
  input  logic [CHAN_W-1:0]   green,
  input  logic [CHAN_W-1:0]   blue,
  input  logic [CHAN_W-1:0]   q_red,
  input  logic [CHAN_W-1:0]   q_green,
  input  logic [CHAN_W-1:0]   q_blue,
  output logic [2*CHAN_W+1:0] dist_sq
);
  import knn_pkg::*;

  localparam int SQ_W   = 2 * CHAN_W;
  localparam int DIST_W = 2 * CHAN_W + 2;

  logic [CHAN_W-1:0] d_r, d_g, d_b;
  logic [SQ_W-1:0]   sq_r, sq_g, sq_b;

  always_comb begin
    d_r     = (red   >= q_red)   ? red   - q_red   : q_red   - red;
    d_g     = (green >= q_green) ? green - q_green : q_green - green;
    d_b     = (blue  >= q_blue)  ? blue  - q_blue  : q_blue  - blue;
    sq_r    = SQ_W'(d_r) * SQ_W'(d_r);
    sq_g    = SQ_W'(d_g) * SQ_W'(d_g);
    sq_b    = SQ_W'(d_b) * SQ_W'(d_b);
    dist_sq = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

endmodule

// File: src/knn_list.sv
// Kept-neighbor list: sorted insert/replace plus running label count.
module knn_list #(
  parameter int N       = 16,
  parameter int LABEL_W = 4,
  parameter int DIST_W  = 34
) (
  input  logic                          clk,
  input  logic                          rst,
  input  knn_pkg::knn_ctl_t             ctl,
  input  logic [DIST_W-1:0]             dist_sq,
  input  logic [LABEL_W-1:0]            label,
  input  logic [knn_pkg::CFG_BITS-1:0]  neighbor_count,
  output knn_pkg::knn_vote_t            vote
);
  import knn_pkg::*;

  localparam int HW = $clog2(N + 1);
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  // Entries sorted ascending by distance; equal distances ordered by
  // descending slot, so the last held entry is the one to evict.
  logic [DIST_W-1:0]  ent_dist  [N];
  logic [LABEL_W-1:0] ent_label [N];
  logic [IW-1:0]      ent_slot  [N];
  logic [HW-1:0]      held;
  logic [HW-1:0]      same_cnt;
  logic [LABEL_W-1:0] query_label;

  logic [HW-1:0]      k;
  logic               add, replace, upd;
  logic [IW-1:0]      far_pos;
  logic [IW-1:0]      new_slot;
  logic [HW-1:0]      lim;
  logic [N-1:0]       ahead, first, wr;
  logic               match_new, match_old;
  logic [HW-1:0]      cnt_after;

  always_comb begin
    if (neighbor_count == '0) begin
      k = HW'(1);
    end else if (32'(neighbor_count) > 32'(N)) begin
      k = HW'(N);
    end else begin
      k = HW'(neighbor_count);
    end

    add      = (held < k) && (held < HW'(N));
    far_pos  = IW'(held - HW'(1));
    replace  = !add && (held != '0) && (dist_sq < ent_dist[far_pos]);
    upd      = ctl.cand && (add || replace);
    new_slot = add ? IW'(held) : ent_slot[far_pos];
    lim      = add ? held : held - HW'(1);

    for (int p = 0; p < N; p++) begin
      ahead[p] = (HW'(p) >= lim) || (dist_sq < ent_dist[p]) ||
                 ((dist_sq == ent_dist[p]) && (new_slot > ent_slot[p]));
    end
    first = ahead & ~(ahead << 1);
    for (int p = 0; p < N; p++) begin
      wr[p] = upd && (HW'(p) <= lim) && ahead[p];
    end

    match_new = (label == query_label);
    match_old = replace && (ent_label[far_pos] == query_label);
    cnt_after = upd ? same_cnt + HW'(match_new) - HW'(match_old) : same_cnt;

    vote.count = COUNT_BITS'(cnt_after);
    vote.keep  = (cnt_after >= (k >> 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= '0;
      same_cnt    <= '0;
      query_label <= '0;
    end else if (ctl.start) begin
      held        <= '0;
      same_cnt    <= '0;
      query_label <= label;
    end else if (upd) begin
      if (add) begin
        held <= held + HW'(1);
      end
      same_cnt <= cnt_after;
    end
  end

  // Entries at and above the insert point shift up by one, up to the
  // freed or newly opened position.
  always_ff @(posedge clk) begin
    for (int p = 0; p < N; p++) begin
      if (wr[p]) begin
        if (first[p]) begin
          ent_dist[p]  <= dist_sq;
          ent_label[p] <= label;
          ent_slot[p]  <= new_slot;
        end else begin
          ent_dist[p]  <= ent_dist[(p == 0) ? 0 : p - 1];
          ent_label[p] <= ent_label[(p == 0) ? 0 : p - 1];
          ent_slot[p]  <= ent_slot[(p == 0) ? 0 : p - 1];
        end
      end
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= HW'(N))
    else $error("kept list overflow");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    same_cnt <= held)
    else $error("label count exceeds kept entries");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> (held == '0) && (same_cnt == '0))
    else $error("start did not clear the list");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (upd && add && !ctl.start) |=> (held == $past(held) + HW'(1)))
    else $error("add did not grow the list");

endmodule

// File: verif/tb_top.sv
// Testbench for the k-nearest-neighbor majority vote filter: directed rows, then random queries.
module tb_top;
  import knn_pkg::*;

  localparam int MAX_N        = 16;
  localparam int CHAN_W       = 16;
  localparam int LABEL_W      = 4;
  localparam int DIST_W       = 2 * CHAN_W + 2;
  // Three register stages to the vote beat, plus spare margin.
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 250000;

  typedef struct packed {
    logic               cmd;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [LABEL_W-1:0] label;
    logic               last;
  } pixel_beat_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // One row of the directed table: a beat, or a register write.
  // Rows with fixed set carry a hand-computed vote instead of the predicted one.
  typedef struct packed {
    row_kind_t           kind;
    logic [CFG_BITS-1:0] cfg_val;
    pixel_beat_t         beat;
    logic                fixed;
    knn_vote_t           vote;
  } plan_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;

  knn_in_if #(.CHAN_W(CHAN_W), .LABEL_W(LABEL_W)) pixel_if ();
  knn_out_if                                      vote_if ();

  knn_majority_vote_filter #(
    .MAX_NEIGHBORS(MAX_N),
    .LABEL_BITS   (LABEL_W),
    .CHANNEL_BITS (CHAN_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .pixel    (pixel_if),
    .vote     (vote_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the kept list, the query and K.
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0]   kept_dist  [MAX_N];
  logic [LABEL_W-1:0]  kept_label [MAX_N];
  int unsigned         held;
  logic [CHAN_W-1:0]   q_red, q_green, q_blue;
  logic [LABEL_W-1:0]  q_label;
  logic [CFG_BITS-1:0] k_reg;

  knn_vote_t   expected_votes [$];
  plan_row_t   directed_plan  [$];
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle    = 17;
  int unsigned snk_idle    = 67;
  bit          hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Register value as the block uses it: 0 means one, anything past the
  // list size means the whole list.
  function automatic int unsigned eff_k();
    if (k_reg == '0) return 1;
    if (32'(k_reg) > MAX_N) return MAX_N;
    return 32'(k_reg);
  endfunction

  function automatic logic [DIST_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] c);
    logic [CHAN_W-1:0] d;
    d = (a >= c) ? a - c : c - a;
    return DIST_W'(d) * DIST_W'(d);
  endfunction

  // Applies one accepted beat to the kept list; reports the vote if the
  // beat is a candidate with last set.
  task automatic predict_vote(input pixel_beat_t b, output logic made, output knn_vote_t v);
    int unsigned       k;
    int unsigned       far;
    int unsigned       cnt;
    logic [DIST_W-1:0] d;
    made = 1'b0;
    v    = '0;
    k    = eff_k();
    if (b.cmd == CMD_START) begin
      q_red   = b.red;
      q_green = b.green;
      q_blue  = b.blue;
      q_label = b.label;
      held    = 0;
    end else begin
      d = sq_diff(b.red, q_red) + sq_diff(b.green, q_green) + sq_diff(b.blue, q_blue);
      if (held < k && held < MAX_N) begin
        kept_dist[held]  = d;
        kept_label[held] = b.label;
        held++;
      end else if (held > 0) begin
        // strict > keeps the lowest slot among equally far entries
        far = 0;
        for (int unsigned i = 1; i < held && i < MAX_N; i++)
          if (kept_dist[i] > kept_dist[far]) far = i;
        if (d < kept_dist[far]) begin
          kept_dist[far]  = d;
          kept_label[far] = b.label;
        end
      end
      if (b.last) begin
        cnt = 0;
        for (int unsigned i = 0; i < held && i < MAX_N; i++)
          if (kept_label[i] == q_label) cnt++;
        made    = 1'b1;
        v.count = COUNT_BITS'(cnt);
        v.keep  = (cnt >= k / 2);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------
  task automatic send_beat(input pixel_beat_t b, input logic fixed, input knn_vote_t fixed_vote);
    logic      made;
    knn_vote_t v;
    while ($urandom_range(99) < src_idle) begin
      pixel_if.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_if.valid <= 1'b1;
    pixel_if.cmd   <= b.cmd;
    pixel_if.red   <= b.red;
    pixel_if.green <= b.green;
    pixel_if.blue  <= b.blue;
    pixel_if.label <= b.label;
    pixel_if.last  <= b.last;
    @(posedge clk);
    while (!pixel_if.ready) @(posedge clk);
    // beat taken at this edge
    predict_vote(b, made, v);
    if (made) begin
      if (fixed) v = fixed_vote;
      expected_votes.insert(expected_votes.size(), v);
    end
  endtask

  // Wait for every vote to drain, then cover beats that are still in flight
  // but produce nothing.
  task automatic settle();
    pixel_if.valid <= 1'b0;
    while (expected_votes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_k(input logic [CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    k_reg      = val;
  endtask

  task automatic plan_beat(input pixel_beat_t b, input logic fixed = 1'b0,
                           input knn_vote_t v = '0);
    plan_row_t r;
    r.kind    = ROW_BEAT;
    r.cfg_val = '0;
    r.beat    = b;
    r.fixed   = fixed;
    r.vote    = v;
    directed_plan.insert(directed_plan.size(), r);
  endtask

  task automatic plan_cfg(input logic [CFG_BITS-1:0] val);
    plan_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.cfg_val = val;
    directed_plan.insert(directed_plan.size(), r);
  endtask

  // Channel value biased toward the ends of the range.
  function automatic logic [CHAN_W-1:0] pick_chan();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return CHAN_W'($urandom);
  endfunction

  function automatic logic [CHAN_W-1:0] near_chan(input logic [CHAN_W-1:0] c);
    return c + CHAN_W'($urandom_range(6)) - CHAN_W'(3);
  endfunction

  function automatic pixel_beat_t noise_beat();
    pixel_beat_t b;
    b.cmd   = 1'($urandom_range(1));
    b.red   = pick_chan();
    b.green = pick_chan();
    b.blue  = pick_chan();
    b.label = LABEL_W'($urandom);
    b.last  = 1'($urandom_range(1));
    return b;
  endfunction

  // One random phase: mostly whole queries (start, candidates, last), with
  // some loose beats mixed in. Candidates often sit close to the query so
  // that distance ties and label matches come up.
  task automatic run_phase(input logic [CFG_BITS-1:0] k, input int unsigned s_idle,
                           input int unsigned r_idle, input int unsigned count,
                           input bit hold);
    int unsigned sent;
    int unsigned n;
    pixel_beat_t q;
    pixel_beat_t b;
    settle();
    write_k(k);
    src_idle = s_idle;
    snk_idle = r_idle;
    if (hold) hold_request = 1'b1;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 85) begin
        q      = noise_beat();
        q.cmd  = CMD_START;
        q.last = ($urandom_range(9) == 0);
        send_beat(q, 1'b0, '0);
        sent++;
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 18);
        for (int unsigned j = 0; j < n; j++) begin
          b     = noise_beat();
          b.cmd = CMD_CAND;
          if ($urandom_range(1)) begin
            b.red   = near_chan(q.red);
            b.green = near_chan(q.green);
            b.blue  = near_chan(q.blue);
          end
          if ($urandom_range(1)) b.label = q.label;
          b.last = (j == n - 1);
          send_beat(b, 1'b0, '0);
          sent++;
        end
      end else begin
        send_beat(noise_beat(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t row;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    pixel_if.valid <= 1'b0;
    pixel_if.cmd   <= CMD_START;
    pixel_if.red   <= '0;
    pixel_if.green <= '0;
    pixel_if.blue  <= '0;
    pixel_if.label <= '0;
    pixel_if.last  <= 1'b0;
    held     = 0;
    q_red    = '0;
    q_green  = '0;
    q_blue   = '0;
    q_label  = '0;
    k_reg    = DEFAULT_NEIGHBORS;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, K = 10 from reset.
    // candidate before any start: compared with the zero query, label 0
    plan_beat('{CMD_CAND,  16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b1}, 1'b1, '{5'd1, 1'b0});
    // start with last set: no vote
    plan_beat('{CMD_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 1'b1});
    // widest distance, then zero distance
    plan_beat('{CMD_CAND,  16'h0000, 16'h0000, 16'h0000, 4'd15, 1'b0});
    plan_beat('{CMD_CAND,  16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 1'b1}, 1'b1, '{5'd2, 1'b0});
    // candidate after last keeps adding to the same list
    plan_beat('{CMD_CAND,  16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd3,  1'b1});
    // K drops below the held count mid-query: nothing is dropped
    plan_cfg(5'd0);
    plan_beat('{CMD_CAND,  16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 1'b1});
    plan_beat('{CMD_CAND,  16'hFFFF, 16'h0000, 16'hFFFF, 4'd15, 1'b1});
    // K = 2, equal distances: lowest slot is the one evicted
    plan_cfg(5'd2);
    plan_beat('{CMD_START, 16'h8000, 16'h8000, 16'h8000, 4'd5,  1'b0});
    plan_beat('{CMD_CAND,  16'h8002, 16'h8000, 16'h8000, 4'd5,  1'b0});
    plan_beat('{CMD_CAND,  16'h7FFE, 16'h8000, 16'h8000, 4'd6,  1'b0});
    plan_beat('{CMD_CAND,  16'h8001, 16'h8000, 16'h8000, 4'd7,  1'b1});
    plan_beat('{CMD_CAND,  16'h8000, 16'h8000, 16'h8000, 4'd5,  1'b1});
    // register above list size acts as the full list
    plan_cfg(5'd31);
    plan_beat('{CMD_START, 16'h1234, 16'hABCD, 16'h5A5A, 4'd10, 1'b0});
    plan_beat('{CMD_CAND,  16'hFFFF, 16'h0000, 16'hFFFF, 4'd10, 1'b0});
    plan_beat('{CMD_CAND,  16'h1234, 16'hABCD, 16'h5A5A, 4'd10, 1'b1});
    plan_cfg(5'd16);
    plan_beat('{CMD_CAND,  16'h0001, 16'h0002, 16'h0003, 4'd2,  1'b1});
    plan_beat('{CMD_START, 16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b0});
    plan_beat('{CMD_CAND,  16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b1}, 1'b1, '{5'd1, 1'b0});

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_k(row.cfg_val);
      end else begin
        send_beat(row.beat, row.fixed, row.vote);
      end
    end

    // Random phases: sender light / receiver heavy, then swapped, then no idling.
    run_phase(5'd1,  17, 67, 155, 1'b0);
    run_phase(5'd16, 17, 67, 155, 1'b0);
    run_phase(5'd31, 67, 17, 155, 1'b0);
    run_phase(5'd0,  67, 17, 155, 1'b0);
    // long receiver hold-off here so the block backs up into its input
    run_phase(CFG_BITS'($urandom_range(2, 15)), 0, 0, 155, 1'b1);
    run_phase(CFG_BITS'($urandom_range(0, 31)), 0, 0, 155, 1'b0);

    settle();
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Vote receiver: random ready, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    vote_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        vote_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        vote_if.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // Each vote beat against the oldest pending expectation.
  always @(posedge clk) begin : check_votes
    knn_vote_t want;
    if (!rst && vote_if.valid && vote_if.ready) begin
      if (expected_votes.size() == 0) begin
        $error("vote beat with nothing pending: count %0d keep %0d",
               vote_if.same_label_count, vote_if.keep);
        err_count++;
      end else begin
        want = expected_votes.pop_front();
        if (vote_if.same_label_count !== want.count) begin
          $error("same_label_count: expected %0d, got %0d", want.count,
                 vote_if.same_label_count);
          err_count++;
        end
        if (vote_if.keep !== want.keep) begin
          $error("keep: expected %0d, got %0d", want.keep, vote_if.keep);
          err_count++;
        end
      end
    end
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule
